### rtl/core/bocp_pkg.sv
// Shared types, constants and the helper function of the open-collector pin decoder.
// Used by the table, pin gate, top level, checker and testbench; depends on nothing.
package bocp_pkg;

    // Field widths fixed by the request and result formats.
    localparam int REQ_W      = 3;
    localparam int BAND_W     = 5;
    localparam int PIN_W      = 7;
    localparam int ACT_W      = 3;
    localparam int PINS       = 7;
    localparam int TBL_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // Request type codes.
    localparam logic [REQ_W-1:0] REQ_COMPUTE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WR_RX_A  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WR_TX_A  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WR_RX_B  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WR_TX_B  = 3'd4;

    // Mask table select codes, used as the upper address bits of the table memory.
    localparam logic [TBL_W-1:0] TBL_RX_A = 2'd0;
    localparam logic [TBL_W-1:0] TBL_TX_A = 2'd1;
    localparam logic [TBL_W-1:0] TBL_RX_B = 2'd2;
    localparam logic [TBL_W-1:0] TBL_TX_B = 2'd3;

    // Transmit action codes of one pin.
    localparam logic [ACT_W-1:0] ACT_MOX          = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TUNE         = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TWOTONE      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MOX_TUNE     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MOX_TWOTONE  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_TUNE_TWOTONE = 3'd5;
    localparam logic [ACT_W-1:0] ACT_ALL          = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_ACTIONS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_AMP_GATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_AMP_GATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_PINS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A_BIT_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VFO_B_TX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_RX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HERMES_TYPE = 3'd7;

    // Every pin uses the widest action (any keying) after reset.
    localparam logic [CFG_DATA_W-1:0] PIN_ACTIONS_RST = 21'd1797558;

    // Request payload.
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [BAND_W-1:0] band_a;
        logic [BAND_W-1:0] band_b;
        logic [PIN_W-1:0]  mask_value;
        logic              transmit;
        logic              tune;
        logic              two_tone;
        logic              amp_on;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic [PIN_W-1:0] oc_bits;
    } t_res;

    // Configuration register file.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pin_actions;
        logic [PIN_W-1:0]      tx_amp_gate;
        logic [PIN_W-1:0]      rx_amp_gate;
        logic                  split_pins;
        logic [PIN_W-1:0]      a_bit_mask;
        logic                  vfo_b_transmits;
        logic                  second_rx_on;
        logic                  hermes_type;
    } t_cfg;

    // Keying and band status that travel with a compute request.
    typedef struct packed {
        logic transmit;
        logic tune;
        logic two_tone;
        logic amp_on;
        logic a_ok;
        logic b_ok;
    } t_ctx;

    // Whether a pin with the given action code is driven for this keying state.
    function automatic logic action_fires(input logic [ACT_W-1:0] code, input logic tx,
                                          input logic tu, input logic tt);
        logic fire;
        case (code)
            ACT_MOX:          fire = tx && !tu && !tt;
            ACT_TUNE:         fire = tu;
            ACT_TWOTONE:      fire = tt;
            ACT_MOX_TUNE:     fire = (tx || tu) && !tt;
            ACT_MOX_TWOTONE:  fire = (tx || tt) && !tu;
            ACT_TUNE_TWOTONE: fire = tu || tt;
            ACT_ALL:          fire = tx || tu || tt;
            default:          fire = 1'b0;
        endcase
        return fire;
    endfunction

endpackage

### rtl/core/bocp_stream_if.sv
// Valid/ready stream channel used for the request and result ports.
// The payload type is a parameter; depends on nothing else.
interface bocp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/bocp_ram.sv
// Generic synchronous RAM: one write port, two read ports with registered data.
// Stand-alone; no package needed.
module bocp_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr0,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr1,
    output logic [WIDTH-1:0]                     o_rdata0,
    output logic [WIDTH-1:0]                     o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Both read ports register their data and hold it while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

### rtl/core/bocp_table.sv
// Mask table store: address selection, table memory, valid bits and the lookup stage.
// Depends on bocp_pkg and bocp_ram.
module bocp_table #(
    parameter int BANDS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  bocp_pkg::t_req               i_req,
    input  bocp_pkg::t_cfg               i_cfg,
    output logic [bocp_pkg::PIN_W-1:0]   o_base,
    output bocp_pkg::t_ctx               o_ctx
);

    localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int AW    = BW + bocp_pkg::TBL_W;
    localparam int DEPTH = 2 ** AW;
    localparam logic [bocp_pkg::BAND_W-1:0] BAND_LIM = bocp_pkg::BAND_W'(BANDS);

    logic                              a_ok;
    logic                              b_ok;
    logic                              is_write;
    logic                              wr_en;
    logic                              rd_en;
    logic [bocp_pkg::TBL_W-1:0]        wr_tbl;
    logic [bocp_pkg::TBL_W-1:0]        rd_tbl_a;
    logic [bocp_pkg::TBL_W-1:0]        rd_tbl_b;
    logic [bocp_pkg::BAND_W-1:0]       sel_band;
    logic [AW-1:0]                     waddr;
    logic [AW-1:0]                     raddr_a;
    logic [AW-1:0]                     raddr_b;
    logic [bocp_pkg::PIN_W-1:0]        ram_a;
    logic [bocp_pkg::PIN_W-1:0]        ram_b;
    logic [bocp_pkg::PIN_W-1:0]        data_a;
    logic [bocp_pkg::PIN_W-1:0]        data_b;
    logic                              zero;
    logic [DEPTH-1:0]                  r_valid;
    logic                              r_va;
    logic                              r_vb;
    logic                              r_zero;
    bocp_pkg::t_ctx                    r_ctx;

    assign a_ok = i_req.band_a < BAND_LIM;
    assign b_ok = i_req.band_b < BAND_LIM;

    // Decode the table that a write request targets.
    always_comb begin
        is_write = 1'b1;
        wr_tbl   = bocp_pkg::TBL_RX_A;
        case (i_req.req_type)
            bocp_pkg::REQ_WR_RX_A: wr_tbl = bocp_pkg::TBL_RX_A;
            bocp_pkg::REQ_WR_TX_A: wr_tbl = bocp_pkg::TBL_TX_A;
            bocp_pkg::REQ_WR_RX_B: wr_tbl = bocp_pkg::TBL_RX_B;
            bocp_pkg::REQ_WR_TX_B: wr_tbl = bocp_pkg::TBL_TX_B;
            default:               is_write = 1'b0;
        endcase
    end

    // Writes to a band outside the table are dropped.
    assign wr_en = i_acc && is_write && a_ok;
    assign rd_en = i_acc && (i_req.req_type == bocp_pkg::REQ_COMPUTE);

    // Pick the band whose A-table entry sets the base mask.
    always_comb begin
        sel_band = i_req.band_a;
        if (i_cfg.split_pins) begin
            sel_band = i_req.band_a;
        end else if (i_cfg.hermes_type) begin
            if (i_req.transmit) begin
                if (i_cfg.vfo_b_transmits && b_ok) begin
                    sel_band = i_req.band_b;
                end
            end else if (i_cfg.second_rx_on && b_ok && (i_req.band_b > i_req.band_a)) begin
                sel_band = i_req.band_b;
            end
        end else if (i_req.transmit && i_cfg.vfo_b_transmits && b_ok) begin
            sel_band = i_req.band_b;
        end
    end

    // Split mode with an invalid band B also clears the result.
    assign zero = !a_ok || (i_cfg.split_pins && !b_ok);

    assign rd_tbl_a = i_req.transmit ? bocp_pkg::TBL_TX_A : bocp_pkg::TBL_RX_A;
    assign rd_tbl_b = i_req.transmit ? bocp_pkg::TBL_TX_B : bocp_pkg::TBL_RX_B;
    assign waddr    = {wr_tbl, i_req.band_a[BW-1:0]};
    assign raddr_a  = {rd_tbl_a, sel_band[BW-1:0]};
    assign raddr_b  = {rd_tbl_b, i_req.band_b[BW-1:0]};

    bocp_ram #(
        .WIDTH (bocp_pkg::PIN_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (wr_en),
        .i_waddr  (waddr),
        .i_wdata  (i_req.mask_value),
        .i_re     (rd_en),
        .i_raddr0 (raddr_a),
        .i_raddr1 (raddr_b),
        .o_rdata0 (ram_a),
        .o_rdata1 (ram_b)
    );

    // Entry valid bits: an entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    // Lookup stage state, loaded together with the memory read data.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_va  <= r_valid[raddr_a];
            r_vb  <= r_valid[raddr_b];
            r_zero <= zero;
            r_ctx <= '{transmit: i_req.transmit, tune: i_req.tune,
                       two_tone: i_req.two_tone, amp_on: i_req.amp_on,
                       a_ok: a_ok, b_ok: b_ok};
        end
    end

    // Combine the A and B entries into the base mask.
    assign data_a = r_va ? ram_a : '0;
    assign data_b = r_vb ? ram_b : '0;

    always_comb begin
        if (r_zero) begin
            o_base = '0;
        end else if (i_cfg.split_pins) begin
            o_base = (data_a & i_cfg.a_bit_mask) | data_b;
        end else begin
            o_base = data_a;
        end
    end

    assign o_ctx = r_ctx;

endmodule

### rtl/core/bocp_pin_gate.sv
// Per-pin gating of the base mask by action codes, amplifier gates and band validity.
// Depends on bocp_pkg.
module bocp_pin_gate (
    input  logic [bocp_pkg::PIN_W-1:0] i_base,
    input  bocp_pkg::t_ctx             i_ctx,
    input  bocp_pkg::t_cfg             i_cfg,
    output logic [bocp_pkg::PIN_W-1:0] o_oc
);

    logic [bocp_pkg::PIN_W-1:0] gate;

    // Each pin is evaluated on its own; pins whose band is invalid stay off.
    always_comb begin
        gate = '0;
        for (int p = 0; p < bocp_pkg::PINS; p++) begin
            logic band_ok;
            logic on;
            if (i_cfg.split_pins) begin
                band_ok = i_cfg.a_bit_mask[p] ? i_ctx.a_ok : i_ctx.b_ok;
            end else begin
                band_ok = i_cfg.vfo_b_transmits ? i_ctx.b_ok : i_ctx.a_ok;
            end
            if (i_ctx.transmit) begin
                on = (!i_cfg.tx_amp_gate[p] || i_ctx.amp_on) &&
                     bocp_pkg::action_fires(i_cfg.pin_actions[p*bocp_pkg::ACT_W +: bocp_pkg::ACT_W],
                                            i_ctx.transmit, i_ctx.tune, i_ctx.two_tone);
            end else begin
                on = !i_cfg.rx_amp_gate[p] || i_ctx.amp_on;
            end
            gate[p] = band_ok && on;
        end
    end

    assign o_oc = i_base & gate;

endmodule

### rtl/core/band_oc_pin_decoder.sv
// Top level of the open-collector pin decoder: configuration registers and pipeline control.
// Depends on bocp_pkg, bocp_stream_if, bocp_table and bocp_pin_gate.
//
// Usage:
//   i_req carries requests. A compute request (band A, band B, transmit, tune,
//   two-tone and amplifier flags) yields one oc_bits result on o_res; a table
//   write request stores mask_value into one of the four per-band mask tables
//   at index band_a and yields nothing. Unknown request types and writes to a
//   band at or beyond BANDS are dropped.
//   Configuration registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_wdata while no request is in flight.
//   The table memory read is issued at the edge that accepts a compute request,
//   which also loads the lookup stage; the output register loads from the lookup
//   stage when it is free, and the result then shows on o_res.
//   Throughput: one request per cycle, set by the single memory read per request,
//   while o_res is not stalled. When o_res is stalled the result holds, one more
//   compute request waits in the lookup stage, and i_req.ready drops until the output drains.
//   Reset clears all tables (through per-entry valid bits), loads the register
//   defaults and empties the pipeline.
module band_oc_pin_decoder #(
    parameter int BANDS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bocp_stream_if.sink                         i_req,
    bocp_stream_if.source                       o_res,
    input  logic                                i_cfg_we,
    input  logic [bocp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bocp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    bocp_pkg::t_req              req;
    bocp_pkg::t_cfg              r_cfg;
    bocp_pkg::t_cfg              n_cfg;
    bocp_pkg::t_ctx              ctx;
    logic [bocp_pkg::PIN_W-1:0]  base;
    logic [bocp_pkg::PIN_W-1:0]  oc;
    logic                        r_s1_valid;
    logic                        r_out_valid;
    bocp_pkg::t_res              r_out;
    logic                        in_ready;
    logic                        in_acc;
    logic                        s1_adv;

    assign req = i_req.data;

    // Configuration register writes.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                bocp_pkg::CFG_PIN_ACTIONS: n_cfg.pin_actions     = i_cfg_wdata;
                bocp_pkg::CFG_TX_AMP_GATE: n_cfg.tx_amp_gate     = i_cfg_wdata[bocp_pkg::PIN_W-1:0];
                bocp_pkg::CFG_RX_AMP_GATE: n_cfg.rx_amp_gate     = i_cfg_wdata[bocp_pkg::PIN_W-1:0];
                bocp_pkg::CFG_SPLIT_PINS:  n_cfg.split_pins      = i_cfg_wdata[0];
                bocp_pkg::CFG_A_BIT_MASK:  n_cfg.a_bit_mask      = i_cfg_wdata[bocp_pkg::PIN_W-1:0];
                bocp_pkg::CFG_VFO_B_TX:    n_cfg.vfo_b_transmits = i_cfg_wdata[0];
                bocp_pkg::CFG_SECOND_RX:   n_cfg.second_rx_on    = i_cfg_wdata[0];
                bocp_pkg::CFG_HERMES_TYPE: n_cfg.hermes_type     = i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{pin_actions: bocp_pkg::PIN_ACTIONS_RST, tx_amp_gate: '0,
                       rx_amp_gate: '0, split_pins: 1'b0, a_bit_mask: '0,
                       vfo_b_transmits: 1'b0, second_rx_on: 1'b0, hermes_type: 1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Handshake: the lookup stage moves on whenever the output register is free.
    assign s1_adv   = r_s1_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_s1_valid || !r_out_valid || o_res.ready;
    assign in_acc   = i_req.valid && in_ready;

    bocp_table #(
        .BANDS (BANDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_req   (req),
        .i_cfg   (r_cfg),
        .o_base  (base),
        .o_ctx   (ctx)
    );

    bocp_pin_gate u_gate (
        .i_base (base),
        .i_ctx  (ctx),
        .i_cfg  (r_cfg),
        .o_oc   (oc)
    );

    // Lookup stage occupancy: only compute requests enter it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc && (req.req_type == bocp_pkg::REQ_COMPUTE)) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.oc_bits <= oc;
        end
    end

    assign i_req.ready = in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

### rtl/core/bocp_checker.sv
// Port-level checks of the open-collector pin decoder, bound to its top level.
// Depends on bocp_pkg and band_oc_pin_decoder.
module bocp_checker #(
    parameter int BANDS = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic [bocp_pkg::REQ_W-1:0]        i_req_type,
    input logic [bocp_pkg::BAND_W-1:0]       i_band_a,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input logic [bocp_pkg::PIN_W-1:0]        i_oc_bits
);

    localparam logic [bocp_pkg::BAND_W-1:0] BAND_LIM = bocp_pkg::BAND_W'(BANDS);

    logic acc_bad_compute;

    assign acc_bad_compute = i_req_valid && i_req_ready &&
                             (i_req_type == bocp_pkg::REQ_COMPUTE) && (i_band_a >= BAND_LIM);

    // A stalled result keeps its value.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_oc_bits))
        else $error("result changed or dropped while stalled");

    // Reset empties the output.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // With the output empty the block always takes a request.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_req_ready)
        else $error("request refused while output empty");

    // A compute with an invalid band A reaches the output as all pins off.
    a_bad_band_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_bad_compute ##1 !i_res_valid |=> i_res_valid && (i_oc_bits == '0))
        else $error("invalid band A gave pins on");

endmodule

bind band_oc_pin_decoder bocp_checker #(
    .BANDS (BANDS)
) u_bocp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.data.req_type),
    .i_band_a    (i_req.data.band_a),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_oc_bits   (o_res.data.oc_bits)
);

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for band_oc_pin_decoder: directed and random requests with an in-order predictor.
// Depends on bocp_pkg, bocp_stream_if and the band_oc_pin_decoder top level.
module tb;

    localparam int BANDS         = 16;
    localparam int CLK_HALF      = 5;
    localparam int RST_CYCLES    = 8;
    localparam int PHASES        = 9;
    localparam int PHASE_REQS    = 150;
    localparam int RX_STALL_LEN  = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    // Action code that keeps a pin off on transmit; request codes past the last write.
    localparam logic [bocp_pkg::ACT_W-1:0] ACT_OFF       = 3'd7;
    localparam logic [bocp_pkg::REQ_W-1:0] REQ_SPARE_A   = bocp_pkg::REQ_WR_TX_B + 3'd1;
    localparam logic [bocp_pkg::REQ_W-1:0] REQ_SPARE_B   = bocp_pkg::REQ_WR_TX_B + 3'd2;
    localparam logic [bocp_pkg::REQ_W-1:0] REQ_LAST_CODE = '1;

    typedef logic [bocp_pkg::PIN_W-1:0] t_pins;

    // One line of the directed script; want is used only where typed is set.
    typedef struct {
        bocp_pkg::t_req req;
        bit             typed;
        t_pins          want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic                            cfg_we;
    logic [bocp_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [bocp_pkg::CFG_DATA_W-1:0] cfg_wdata;

    bocp_stream_if #(.T(bocp_pkg::t_req)) req_if ();
    bocp_stream_if #(.T(bocp_pkg::t_res)) res_if ();

    band_oc_pin_decoder #(
        .BANDS(BANDS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    // Shadow copy of the mask tables and the register file.
    t_pins          rx_mask_a [BANDS];
    t_pins          tx_mask_a [BANDS];
    t_pins          rx_mask_b [BANDS];
    t_pins          tx_mask_b [BANDS];
    bocp_pkg::t_cfg cfg_shadow;

    t_pins oc_expected [$];
    t_row  pin_script [$];
    int    fail_count;
    int    mismatch_count;
    int    send_idle_pct;
    int    recv_idle_pct;
    bit    stall_kick;
    bit    stall_ack;
    int    stall_left;
    int    cycle_count;

    // Free-running clock.
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Whether a pin with this action code drives while transmit is keyed.
    function automatic bit keyed_action_on(input logic [bocp_pkg::ACT_W-1:0] code,
                                           input logic tu, input logic tt);
        case (code)
            bocp_pkg::ACT_MOX:          return !tu && !tt;
            bocp_pkg::ACT_TUNE:         return tu;
            bocp_pkg::ACT_TWOTONE:      return tt;
            bocp_pkg::ACT_MOX_TUNE:     return !tt;
            bocp_pkg::ACT_MOX_TWOTONE:  return !tu;
            bocp_pkg::ACT_TUNE_TWOTONE: return tu || tt;
            bocp_pkg::ACT_ALL:          return 1'b1;
            default:                    return 1'b0;
        endcase
    endfunction

    // Applies one request to the shadow state; returns 1 with the pin states for a compute.
    function automatic bit decode_pins(input bocp_pkg::t_req r, output t_pins oc);
        bit         a_ok;
        bit         b_ok;
        logic [3:0] ia;
        logic [3:0] ib;
        t_pins      base;
        t_pins      gate;
        bit         band_ok;
        bit         on;
        a_ok = r.band_a < BANDS;
        b_ok = r.band_b < BANDS;
        ia   = r.band_a[3:0];
        ib   = r.band_b[3:0];
        oc   = '0;
        base = '0;
        gate = '0;

        // Table writes land only on a valid entry; unknown codes are dropped.
        if (r.req_type != bocp_pkg::REQ_COMPUTE) begin
            if (a_ok) begin
                case (r.req_type)
                    bocp_pkg::REQ_WR_RX_A: rx_mask_a[ia] = r.mask_value;
                    bocp_pkg::REQ_WR_TX_A: tx_mask_a[ia] = r.mask_value;
                    bocp_pkg::REQ_WR_RX_B: rx_mask_b[ia] = r.mask_value;
                    bocp_pkg::REQ_WR_TX_B: tx_mask_b[ia] = r.mask_value;
                    default: ;
                endcase
            end
            return 1'b0;
        end

        // Base mask selection.
        if (!a_ok || (cfg_shadow.split_pins && !b_ok)) begin
            base = '0;
        end else if (cfg_shadow.split_pins) begin
            if (r.transmit)
                base = (tx_mask_a[ia] & cfg_shadow.a_bit_mask) | tx_mask_b[ib];
            else
                base = (rx_mask_a[ia] & cfg_shadow.a_bit_mask) | rx_mask_b[ib];
        end else if (cfg_shadow.hermes_type) begin
            if (r.transmit)
                base = (cfg_shadow.vfo_b_transmits && b_ok) ? tx_mask_a[ib] : tx_mask_a[ia];
            else if (cfg_shadow.second_rx_on && b_ok && r.band_b > r.band_a)
                base = rx_mask_a[ib];
            else
                base = rx_mask_a[ia];
        end else begin
            if (r.transmit)
                base = (cfg_shadow.vfo_b_transmits && b_ok) ? tx_mask_a[ib] : tx_mask_a[ia];
            else
                base = rx_mask_a[ia];
        end

        // Per-pin gating by band validity, action code and amplifier gates.
        for (int p = 0; p < bocp_pkg::PINS; p++) begin
            if (cfg_shadow.split_pins)
                band_ok = cfg_shadow.a_bit_mask[p] ? a_ok : b_ok;
            else
                band_ok = cfg_shadow.vfo_b_transmits ? b_ok : a_ok;
            if (r.transmit)
                on = (!cfg_shadow.tx_amp_gate[p] || r.amp_on)
                     && keyed_action_on(
                            cfg_shadow.pin_actions[bocp_pkg::ACT_W*p +: bocp_pkg::ACT_W],
                            r.tune, r.two_tone);
            else
                on = !cfg_shadow.rx_amp_gate[p] || r.amp_on;
            gate[p] = band_ok && on;
        end
        oc = base & gate;
        return 1'b1;
    endfunction

    function automatic t_row row(input logic [bocp_pkg::REQ_W-1:0] kind,
                                 input logic [bocp_pkg::BAND_W-1:0] ba,
                                 input logic [bocp_pkg::BAND_W-1:0] bb, input t_pins mv,
                                 input logic [3:0] keys, input bit typed, input t_pins want);
        t_row x;
        x.req.req_type   = kind;
        x.req.band_a     = ba;
        x.req.band_b     = bb;
        x.req.mask_value = mv;
        {x.req.transmit, x.req.tune, x.req.two_tone, x.req.amp_on} = keys;
        x.typed = typed;
        x.want  = want;
        return x;
    endfunction

    // Random request: mostly computes and table writes on valid bands, some noise.
    function automatic bocp_pkg::t_req random_request();
        bocp_pkg::t_req r;
        int             roll;
        roll         = $urandom_range(0, 99);
        r.band_a     = ($urandom_range(0, 9) == 0)
                       ? bocp_pkg::BAND_W'($urandom_range(BANDS, 31))
                       : bocp_pkg::BAND_W'($urandom_range(0, BANDS - 1));
        r.band_b     = ($urandom_range(0, 9) == 0)
                       ? bocp_pkg::BAND_W'($urandom_range(BANDS, 31))
                       : bocp_pkg::BAND_W'($urandom_range(0, BANDS - 1));
        r.mask_value = bocp_pkg::PIN_W'($urandom_range(0, 127));
        r.transmit   = 1'($urandom_range(0, 1));
        r.tune       = 1'($urandom_range(0, 1));
        r.two_tone   = 1'($urandom_range(0, 1));
        r.amp_on     = 1'($urandom_range(0, 1));
        if (roll < 8)
            r.req_type = bocp_pkg::REQ_W'($urandom_range(REQ_SPARE_A, REQ_LAST_CODE));
        else if (roll < 38)
            r.req_type = bocp_pkg::REQ_W'($urandom_range(bocp_pkg::REQ_WR_RX_A,
                                                         bocp_pkg::REQ_WR_TX_B));
        else
            r.req_type = bocp_pkg::REQ_COMPUTE;
        return r;
    endfunction

    function automatic bocp_pkg::t_cfg random_settings();
        bocp_pkg::t_cfg c;
        c.pin_actions     = bocp_pkg::CFG_DATA_W'($urandom_range(0, 21'h1FFFFF));
        c.tx_amp_gate     = bocp_pkg::PIN_W'($urandom_range(0, 127));
        c.rx_amp_gate     = bocp_pkg::PIN_W'($urandom_range(0, 127));
        c.split_pins      = 1'($urandom_range(0, 1));
        c.a_bit_mask      = bocp_pkg::PIN_W'($urandom_range(0, 127));
        c.vfo_b_transmits = 1'($urandom_range(0, 1));
        c.second_rx_on    = 1'($urandom_range(0, 1));
        c.hermes_type     = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // One register write; the shadow follows. The caller drops the write enable.
    task automatic write_reg(input logic [bocp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bocp_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            bocp_pkg::CFG_PIN_ACTIONS: cfg_shadow.pin_actions     = val;
            bocp_pkg::CFG_TX_AMP_GATE: cfg_shadow.tx_amp_gate     = val[bocp_pkg::PIN_W-1:0];
            bocp_pkg::CFG_RX_AMP_GATE: cfg_shadow.rx_amp_gate     = val[bocp_pkg::PIN_W-1:0];
            bocp_pkg::CFG_SPLIT_PINS:  cfg_shadow.split_pins      = val[0];
            bocp_pkg::CFG_A_BIT_MASK:  cfg_shadow.a_bit_mask      = val[bocp_pkg::PIN_W-1:0];
            bocp_pkg::CFG_VFO_B_TX:    cfg_shadow.vfo_b_transmits = val[0];
            bocp_pkg::CFG_SECOND_RX:   cfg_shadow.second_rx_on    = val[0];
            bocp_pkg::CFG_HERMES_TYPE: cfg_shadow.hermes_type     = val[0];
            default: ;
        endcase
    endtask

    // Writes every register on consecutive edges, then drops the write enable.
    task automatic load_settings(input bocp_pkg::t_cfg c);
        write_reg(bocp_pkg::CFG_PIN_ACTIONS, c.pin_actions);
        write_reg(bocp_pkg::CFG_TX_AMP_GATE, bocp_pkg::CFG_DATA_W'(c.tx_amp_gate));
        write_reg(bocp_pkg::CFG_RX_AMP_GATE, bocp_pkg::CFG_DATA_W'(c.rx_amp_gate));
        write_reg(bocp_pkg::CFG_SPLIT_PINS, bocp_pkg::CFG_DATA_W'(c.split_pins));
        write_reg(bocp_pkg::CFG_A_BIT_MASK, bocp_pkg::CFG_DATA_W'(c.a_bit_mask));
        write_reg(bocp_pkg::CFG_VFO_B_TX, bocp_pkg::CFG_DATA_W'(c.vfo_b_transmits));
        write_reg(bocp_pkg::CFG_SECOND_RX, bocp_pkg::CFG_DATA_W'(c.second_rx_on));
        write_reg(bocp_pkg::CFG_HERMES_TYPE, bocp_pkg::CFG_DATA_W'(c.hermes_type));
        cfg_we <= 1'b0;
    endtask

    // Stops offering, waits for every pending result and lets the pipeline settle.
    task automatic drain_pipeline();
        req_if.valid <= 1'b0;
        while (oc_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offers one request after a random gap; predicts it at the accepting edge.
    task automatic send_request(input bocp_pkg::t_req r, input bit typed, input t_pins want);
        t_pins oc;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        if (decode_pins(r, oc))
            oc_expected.push_back(typed ? want : oc);
    endtask

    // Result side: random back-pressure, long hold-off on request, and the checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (oc_expected.size() == 0) begin
                    fail_count++;
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected result oc_bits=%h", res_if.data.oc_bits);
                    mismatch_count++;
                end else if (res_if.data.oc_bits !== oc_expected[0]) begin
                    fail_count++;
                    if (mismatch_count < MAX_REPORTS)
                        $display("oc_bits: expected %h, got %h",
                                 oc_expected[0], res_if.data.oc_bits);
                    mismatch_count++;
                    void'(oc_expected.pop_front());
                end else begin
                    void'(oc_expected.pop_front());
                end
            end
            if (stall_kick != stall_ack) begin
                stall_ack  <= stall_kick;
                stall_left <= RX_STALL_LEN;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end
            res_if.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("band_oc_pin_decoder: mismatch");
            $finish;
        end
    end

    // Main sequence: reset, directed script under two settings, then random phases.
    initial begin
        bocp_pkg::t_cfg special;
        bocp_pkg::t_cfg c;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_wdata     = '0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        res_if.ready  = 1'b0;
        fail_count    = 0;
        mismatch_count = 0;
        send_idle_pct = 6;
        recv_idle_pct = 66;
        stall_kick    = 1'b0;
        stall_ack     = 1'b0;
        stall_left    = 0;
        cycle_count   = 0;
        for (int i = 0; i < BANDS; i++) begin
            rx_mask_a[i] = '0;
            tx_mask_a[i] = '0;
            rx_mask_b[i] = '0;
            tx_mask_b[i] = '0;
        end
        cfg_shadow.pin_actions     = bocp_pkg::PIN_ACTIONS_RST;
        cfg_shadow.tx_amp_gate     = '0;
        cfg_shadow.rx_amp_gate     = '0;
        cfg_shadow.split_pins      = 1'b0;
        cfg_shadow.a_bit_mask      = '0;
        cfg_shadow.vfo_b_transmits = 1'b0;
        cfg_shadow.second_rx_on    = 1'b0;
        cfg_shadow.hermes_type     = 1'b0;

        // Directed script; typed results hold under the reset settings.
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd0, 5'd0, 7'h00, 4'b0000, 1'b1, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd31, 5'd31, 7'h7F, 4'b1111,
                                 1'b1, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_WR_RX_A, 5'd0, 5'd0, 7'h7F, 4'b0000, 1'b0, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_WR_TX_A, 5'd15, 5'd31, 7'h7F, 4'b1111,
                                 1'b0, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_WR_RX_B, 5'd15, 5'd0, 7'h2A, 4'b0000, 1'b0, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_WR_TX_B, 5'd0, 5'd0, 7'h55, 4'b0000, 1'b0, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_WR_RX_B, 5'd1, 5'd0, 7'h00, 4'b0000, 1'b0, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_WR_RX_A, 5'd16, 5'd0, 7'h7F, 4'b0000, 1'b0, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_WR_TX_A, 5'd31, 5'd0, 7'h7F, 4'b0000, 1'b0, 7'h00));
        pin_script.push_back(row(REQ_SPARE_A, 5'd0, 5'd0, 7'h7F, 4'b1111, 1'b0, 7'h00));
        pin_script.push_back(row(REQ_SPARE_B, 5'd15, 5'd15, 7'h00, 4'b0000, 1'b0, 7'h00));
        pin_script.push_back(row(REQ_LAST_CODE, 5'd31, 5'd31, 7'h7F, 4'b1111, 1'b0, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd0, 5'd0, 7'h00, 4'b0000, 1'b1, 7'h7F));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd15, 5'd0, 7'h00, 4'b1000, 1'b1, 7'h7F));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd15, 5'd15, 7'h00, 4'b0000,
                                 1'b1, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd16, 5'd0, 7'h00, 4'b0000, 1'b1, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd0, 5'd31, 7'h00, 4'b0000, 1'b1, 7'h7F));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd15, 5'd15, 7'h00, 4'b1111,
                                 1'b1, 7'h7F));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd15, 5'd3, 7'h00, 4'b0111, 1'b0, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_WR_RX_A, 5'd15, 5'd0, 7'h01, 4'b0000, 1'b0, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd15, 5'd0, 7'h00, 4'b0000, 1'b1, 7'h01));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd0, 5'd0, 7'h00, 4'b1000, 1'b1, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_WR_TX_A, 5'd0, 5'd0, 7'h40, 4'b0000, 1'b0, 7'h00));
        pin_script.push_back(row(bocp_pkg::REQ_COMPUTE, 5'd0, 5'd15, 7'h00, 4'b1010, 1'b0, 7'h00));

        // Reset, released at a clock edge.
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (pin_script[i])
            send_request(pin_script[i].req, pin_script[i].typed, pin_script[i].want);
        drain_pipeline();

        // Same script again with split pins, mixed action codes and amplifier gates.
        special.pin_actions     = {bocp_pkg::ACT_TUNE_TWOTONE, bocp_pkg::ACT_MOX_TWOTONE,
                                   bocp_pkg::ACT_MOX_TUNE, bocp_pkg::ACT_TWOTONE,
                                   bocp_pkg::ACT_TUNE, bocp_pkg::ACT_MOX, ACT_OFF};
        special.tx_amp_gate     = 7'h0F;
        special.rx_amp_gate     = 7'h70;
        special.split_pins      = 1'b1;
        special.a_bit_mask      = 7'h55;
        special.vfo_b_transmits = 1'b1;
        special.second_rx_on    = 1'b1;
        special.hermes_type     = 1'b1;
        load_settings(special);
        foreach (pin_script[i])
            send_request(pin_script[i].req, 1'b0, '0);
        drain_pipeline();

        // Random phases, each under its own settings and one of three idle patterns.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 66;
            end else if (ph < 6) begin
                send_idle_pct = 66;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 0) begin
                c = '0;
            end else if (ph == 1) begin
                c = '1;
            end else begin
                c = random_settings();
            end
            load_settings(c);
            for (int n = 0; n < PHASE_REQS; n++) begin
                // Long receiver hold-off while requests keep coming.
                if (ph == 2 && n == 40)
                    stall_kick = ~stall_kick;
                // Sender waits for every pending result before going on.
                if (ph == 4 && n == 75)
                    drain_pipeline();
                send_request(random_request(), 1'b0, '0);
            end
            drain_pipeline();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        fail_count += oc_expected.size();
        if (fail_count == 0)
            $display("band_oc_pin_decoder: match");
        else
            $display("band_oc_pin_decoder: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/core/bocp_pkg.sv
rtl/core/bocp_stream_if.sv
rtl/core/bocp_ram.sv
rtl/core/bocp_table.sv
rtl/core/bocp_pin_gate.sv
rtl/core/band_oc_pin_decoder.sv
rtl/core/bocp_checker.sv
tb/tb.sv
